[hdl/prc_pkg.sv]
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants of the prime range counter
// Sizes of the prime map and the value store, sequencer states, and the
// control groups that pass between the sieve, the store and the query walker.
// ----------------------------------------------------------------------------
package prc_pkg;

   localparam int VALUE_BITS     = 16;
   localparam int DATA_DEPTH     = 1024;
   localparam int MAP_SIZE       = 1 << VALUE_BITS;
   localparam int DATA_BITS      = 16;
   localparam int COUNT_OUT_BITS = 11;
   localparam int COUNT_BITS     = $clog2(DATA_DEPTH + 1);
   localparam int ADDR_BITS      = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam int WIDE_BITS      = (VALUE_BITS > DATA_BITS) ? VALUE_BITS : DATA_BITS;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [2:0] {
      SV_FILL,
      SV_READ,
      SV_CHECK,
      SV_MARK,
      SV_DONE
   } sieve_state_type;

   typedef enum logic [1:0] {
      QS_IDLE,
      QS_WALK,
      QS_DRAIN,
      QS_FINISH
   } query_state_type;

   typedef struct packed {
      logic done;
      logic prime;
   } sieve_status_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [DATA_BITS-1:0] wr_data;
      logic [ADDR_BITS-1:0] rd_addr;
   } store_cmd_type;

   function automatic logic [VALUE_BITS-1:0] map_addr(input logic [DATA_BITS-1:0] value);
      logic [WIDE_BITS-1:0] wide;
      wide = WIDE_BITS'(value);
      return wide[VALUE_BITS-1:0];
   endfunction

   function automatic logic in_map(input logic [DATA_BITS-1:0] value);
      logic [WIDE_BITS-1:0] wide;
      wide = WIDE_BITS'(value);
      return (wide >> VALUE_BITS) == '0;
   endfunction

endpackage

[hdl/prc_if.sv]
// ----------------------------------------------------------------------------
// prc_if: request and response channels of the prime range counter
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface prc_req_if import prc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [DATA_BITS-1:0] data_value;
   logic [DATA_BITS-1:0] range_low;
   logic [DATA_BITS-1:0] range_high;

   modport source (output valid, kind, data_value, range_low, range_high, input ready);
   modport sink   (input valid, kind, data_value, range_low, range_high, output ready);
endinterface

interface prc_rsp_if import prc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [COUNT_OUT_BITS-1:0] prime_count;

   modport source (output valid, prime_count, input ready);
   modport sink   (input valid, prime_count, output ready);
endinterface

[hdl/prc_sieve.sv]
// ----------------------------------------------------------------------------
// prc_sieve: prime map builder and lookup
// After reset, fills the map and strikes out multiples of each prime found,
// then serves one registered map read per cycle to the query walker.
// ----------------------------------------------------------------------------
module prc_sieve import prc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [VALUE_BITS-1:0] look_addr,
   output sieve_status_type      status
);

   logic                    map_mem [MAP_SIZE];
   logic                    rd_bit_ff;
   sieve_state_type         state_ff, state_in;
   logic [VALUE_BITS-1:0]   fill_ff, fill_in;
   logic [VALUE_BITS-1:0]   i_ff, i_in;
   logic [VALUE_BITS-1:0]   j_ff, j_in;
   logic [2*VALUE_BITS-1:0] sq_ff, sq_in;
   logic                    wr_en;
   logic [VALUE_BITS-1:0]   wr_addr;
   logic                    wr_bit;
   logic [VALUE_BITS-1:0]   rd_addr;
   logic [VALUE_BITS:0]     j_step;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_bit;
      end
      rd_bit_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SV_FILL;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff  <= i_in;
      j_ff  <= j_in;
      sq_ff <= sq_in;
   end

   assign j_step  = {1'b0, j_ff} + {1'b0, i_ff};
   assign rd_addr = (state_ff == SV_DONE) ? look_addr : i_ff;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      sq_in    = sq_ff;
      wr_en    = 1'b0;
      wr_addr  = fill_ff;
      wr_bit   = 1'b0;
      unique case (state_ff)
         SV_FILL: begin
            wr_en   = 1'b1;
            wr_bit  = (fill_ff >= VALUE_BITS'(2));
            fill_in = fill_ff + VALUE_BITS'(1);
            if (fill_ff == '1) begin
               i_in     = VALUE_BITS'(2);
               state_in = SV_READ;
            end
         end
         SV_READ: begin
            // map bit of i comes back next cycle, square registered alongside
            sq_in    = (2*VALUE_BITS)'(i_ff) * (2*VALUE_BITS)'(i_ff);
            state_in = SV_CHECK;
         end
         SV_CHECK: begin
            if (sq_ff[2*VALUE_BITS-1:VALUE_BITS] != '0) begin
               state_in = SV_DONE;
            end else if (rd_bit_ff) begin
               j_in     = sq_ff[VALUE_BITS-1:0];
               state_in = SV_MARK;
            end else begin
               i_in     = i_ff + VALUE_BITS'(1);
               state_in = SV_READ;
            end
         end
         SV_MARK: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            if (j_step[VALUE_BITS]) begin
               i_in     = i_ff + VALUE_BITS'(1);
               state_in = SV_READ;
            end else begin
               j_in = j_step[VALUE_BITS-1:0];
            end
         end
         SV_DONE: begin
            state_in = SV_DONE;
         end
         default: begin
            state_in = SV_FILL;
         end
      endcase
   end

   assign status.done  = (state_ff == SV_DONE);
   assign status.prime = rd_bit_ff;

endmodule

[hdl/prc_store.sv]
// ----------------------------------------------------------------------------
// prc_store: value store
// One write port for appended values, one registered read port for the walk.
// ----------------------------------------------------------------------------
module prc_store import prc_pkg::*; (
   input  logic                 clock,
   input  store_cmd_type        cmd,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] store_mem [DATA_DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_data_ff <= store_mem[cmd.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/prc_query.sv]
// ----------------------------------------------------------------------------
// prc_query: request sequencer and range walker
// Takes append and query words, walks the store one entry a cycle through
// store read, map read and count stages, and holds the result for the sink.
// ----------------------------------------------------------------------------
module prc_query import prc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   prc_req_if.sink                req,
   prc_rsp_if.source              rsp,
   input  sieve_status_type       sieve_status,
   input  logic [DATA_BITS-1:0]   store_data,
   output store_cmd_type          store_cmd,
   output logic [VALUE_BITS-1:0]  look_addr
);

   query_state_type           state_ff, state_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [COUNT_BITS-1:0]     idx_ff, idx_in;
   logic [COUNT_BITS-1:0]     idx_next;
   logic [DATA_BITS-1:0]      lo_ff, lo_in;
   logic [DATA_BITS-1:0]      hi_ff, hi_in;
   logic [COUNT_OUT_BITS-1:0] acc_ff, acc_in;
   logic                      s1_ff, s1_in;
   logic                      s2_ff, s2_in;
   logic                      rng_ff, rng_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= QS_IDLE;
         count_ff     <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      acc_ff       <= acc_in;
      rng_ff       <= rng_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req.ready       = (state_ff == QS_IDLE) && sieve_status.done;
   assign accept          = req.valid && req.ready;
   assign idx_next        = idx_ff + COUNT_BITS'(1);
   assign look_addr       = map_addr(store_data);
   assign rng_in          = (store_data >= lo_ff) && (store_data <= hi_ff) && in_map(store_data);
   assign s2_in           = s1_ff;

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      idx_in            = idx_ff;
      lo_in             = lo_ff;
      hi_in             = hi_ff;
      acc_in            = acc_ff;
      s1_in             = 1'b0;
      rsp_valid_in      = rsp_valid_ff;
      rsp_count_in      = rsp_count_ff;
      store_cmd.wr_en   = 1'b0;
      store_cmd.wr_addr = count_ff[ADDR_BITS-1:0];
      store_cmd.wr_data = req.data_value;
      store_cmd.rd_addr = idx_ff[ADDR_BITS-1:0];

      // drop the result once the sink takes it
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      // count a hit, hold at full scale
      if (s2_ff && rng_ff && sieve_status.prime && (acc_ff != '1)) begin
         acc_in = acc_ff + COUNT_OUT_BITS'(1);
      end

      unique case (state_ff)
         QS_IDLE: begin
            if (accept) begin
               if (req.kind == KIND_LOAD) begin
                  if (count_ff != COUNT_BITS'(DATA_DEPTH)) begin
                     store_cmd.wr_en = 1'b1;
                     count_in        = count_ff + COUNT_BITS'(1);
                  end
               end else begin
                  lo_in  = req.range_low;
                  hi_in  = req.range_high;
                  acc_in = '0;
                  idx_in = '0;
                  if ((req.range_low > req.range_high) || (count_ff == '0)) begin
                     state_in = QS_FINISH;
                  end else begin
                     state_in = QS_WALK;
                  end
               end
            end
         end
         QS_WALK: begin
            s1_in  = 1'b1;
            idx_in = idx_next;
            if (idx_next == count_ff) begin
               state_in = QS_DRAIN;
            end
         end
         QS_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = QS_FINISH;
            end
         end
         QS_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = acc_ff;
               state_in     = QS_IDLE;
            end
         end
         default: begin
            state_in = QS_IDLE;
         end
      endcase
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.prime_count = rsp_count_ff;

endmodule

[hdl/prime_range_counter_top.sv]
// ----------------------------------------------------------------------------
// prime_range_counter_top: counts stored primes inside a query range
// Request channel (req_ch): kind 0 appends data_value to the value store,
// kind 1 asks how many stored values in [range_low, range_high] are prime.
// Response channel (rsp_ch): one prime_count word per query, none per append.
// After reset the sieve builds the prime map: one fill pass over all
// 2^VALUE_BITS entries, then a check of each candidate and a strike of each
// multiple of each prime found. req_ch.ready stays low until done.
// A query walks the stored values through the single store read port, one
// entry a cycle; an empty range or an empty store skips the walk. The block
// takes one word at a time and is not ready while a query walks.
// The result sits in an output register; an append is taken while it waits.
// If the sink stalls, a finished query holds until the register is free.
// Reset empties the value store and restarts the sieve.
// ----------------------------------------------------------------------------
module prime_range_counter_top import prc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   prc_req_if.sink   req_ch,
   prc_rsp_if.source rsp_ch
);

   sieve_status_type      sieve_status;
   store_cmd_type         store_cmd;
   logic [DATA_BITS-1:0]  store_data;
   logic [VALUE_BITS-1:0] look_addr;

   prc_sieve u_sieve (
      .clock     (clock),
      .reset     (reset),
      .look_addr (look_addr),
      .status    (sieve_status)
   );

   prc_store u_store (
      .clock   (clock),
      .cmd     (store_cmd),
      .rd_data (store_data)
   );

   prc_query u_query (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .sieve_status (sieve_status),
      .store_data   (store_data),
      .store_cmd    (store_cmd),
      .look_addr    (look_addr)
   );

endmodule

[hdl/prc_checker.sv]
// ----------------------------------------------------------------------------
// prc_checker: port-level checks of the prime range counter
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module prc_checker import prc_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_kind,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [COUNT_OUT_BITS-1:0] rsp_prime_count
);

   // sieve runs after reset, nothing is pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!req_ready && !rsp_valid))
      else $error("ready or response seen right after reset");

   // a query keeps the block busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == KIND_QUERY)) |=> !req_ready)
      else $error("ready right after a query word");

   // an append never raises a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == KIND_LOAD) && !rsp_valid) |=> !rsp_valid)
      else $error("response after an append");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_prime_count)))
      else $error("stalled response word changed");

endmodule

bind prime_range_counter_top prc_checker u_prc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_kind        (req_ch.kind),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_prime_count (rsp_ch.prime_count)
);
